// ===== rtl/core/dsps_pkg.sv =====
// Shared types and constants for the dual servo pulse generator with slew limit.
// Used by dsps_chan and dual_servo_pwm_slew_top; depends on nothing else.
`default_nettype none

package dsps_pkg;

    localparam int unsigned CountW  = 12;
    localparam int unsigned WidthW  = 9;
    localparam int unsigned AngleW  = 8;
    localparam int unsigned StepW   = 8;
    localparam int unsigned OffsetW = 8;
    localparam int unsigned CfgW    = 12;

    localparam logic [CountW-1:0]  RST_FRAME_TICKS = 12'd2000;
    localparam logic [OffsetW-1:0] RST_OFFSET      = 8'd60;
    localparam logic [WidthW-1:0]  RST_WIDTH       = 9'd60;
    localparam logic [StepW-1:0]   FRAMES_MAX      = 8'd255;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_SET_BASE   = 2'd1;
    localparam logic [1:0] OP_SET_MAGNET = 2'd2;

    localparam logic REG_FRAME_TICKS  = 1'b0;
    localparam logic REG_ANGLE_OFFSET = 1'b1;

    typedef struct packed {
        logic [1:0]        op;
        logic [AngleW-1:0] angle;
        logic [StepW-1:0]  step_frames;
    } t_in_word;

    typedef struct packed {
        logic              base_pulse;
        logic              magnet_pulse;
        logic [WidthW-1:0] base_width;
        logic [WidthW-1:0] magnet_width;
        logic              base_moving;
        logic              magnet_moving;
        logic              frame_end;
    } t_out_word;

    typedef struct packed {
        logic              tick;
        logic              wrapped;
        logic [CountW:0]   count;
        logic              set;
        logic [WidthW-1:0] target;
        logic [StepW-1:0]  interval;
    } t_chan_cmd;

    typedef struct packed {
        logic              level;
        logic [WidthW-1:0] width;
        logic              moving;
    } t_chan_stat;

endpackage

`default_nettype wire

// ===== rtl/core/dsps_chan.sv =====
// One servo channel: width, target, step interval, frame count and held level.
// Depends on dsps_pkg for the command and status structs.
`default_nettype none

module dsps_chan
    import dsps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_adv,
    input  wire t_chan_cmd  i_cmd,
    output t_chan_stat      o_stat
);

    logic [WidthW-1:0] r_pw, n_pw;
    logic [WidthW-1:0] r_target, n_target;
    logic [StepW-1:0]  r_interval, n_interval;
    logic [StepW-1:0]  r_frames, n_frames;
    logic              r_level, n_level;
    logic [WidthW-1:0] stepped_pw;
    logic [StepW-1:0]  inc_frames;

    always_comb begin
        if (r_pw < r_target) begin
            stepped_pw = r_pw + 9'd1;
        end else if (r_pw > r_target) begin
            stepped_pw = r_pw - 9'd1;
        end else begin
            stepped_pw = r_pw;
        end
        inc_frames = (r_frames == FRAMES_MAX) ? FRAMES_MAX : r_frames + 8'd1;

        n_pw       = r_pw;
        n_target   = r_target;
        n_interval = r_interval;
        n_frames   = r_frames;
        n_level    = r_level;
        if (i_cmd.set) begin
            n_target   = i_cmd.target;
            n_interval = i_cmd.interval;
            n_frames   = '0;
        end else if (i_cmd.tick) begin
            n_level = (i_cmd.count < {4'd0, r_pw});
            if (r_interval == '0) begin
                n_pw = stepped_pw;
            end else if (i_cmd.wrapped) begin
                if (inc_frames >= r_interval) begin
                    n_pw     = stepped_pw;
                    n_frames = '0;
                end else begin
                    n_frames = inc_frames;
                end
            end
        end
    end

    assign o_stat.level  = n_level;
    assign o_stat.width  = n_pw;
    assign o_stat.moving = (n_pw != n_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw       <= RST_WIDTH;
            r_target   <= RST_WIDTH;
            r_interval <= '0;
            r_frames   <= '0;
            r_level    <= 1'b0;
        end else if (i_adv) begin
            r_pw       <= n_pw;
            r_target   <= n_target;
            r_interval <= n_interval;
            r_frames   <= n_frames;
            r_level    <= n_level;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dual_servo_pwm_slew_top.sv =====
// Top level of the two-channel servo pulse generator with slew-rate limit.
// An accepted word passes the input register and then the result register, which
// drives the output. Throughput is one word per cycle; the input register and the
// result register each hold one word, so the input stalls only when the result
// register is full and stalled. Synchronous active-low reset restores the register
// defaults, widths and targets of 60 ticks, a zero counter and cleared valid flags.
`default_nettype none

module dual_servo_pwm_slew_top
    import dsps_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [CfgW-1:0] i_cfg_data,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire t_in_word        i_in_word,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out_word            o_out_word
);

    logic [CountW-1:0]  r_frame_ticks;
    logic [OffsetW-1:0] r_angle_offset;
    logic [CountW-1:0]  r_tick_count, n_tick_count;
    logic               r_in_valid;
    t_in_word           r_in_word;
    logic               r_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               adv;
    logic [CountW:0]    count;
    logic               wrapped;
    logic               is_tick;
    logic               set_base;
    logic               set_magnet;
    logic [WidthW-1:0]  target;
    t_chan_cmd          base_cmd, magnet_cmd;
    t_chan_stat         base_stat, magnet_stat;

    assign adv        = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !adv;

    assign count   = {1'b0, r_tick_count} + 13'd1;
    assign wrapped = (count >= {1'b0, r_frame_ticks});
    assign target  = {1'b0, r_in_word.angle} + {1'b0, r_angle_offset};

    always_comb begin
        is_tick    = 1'b0;
        set_base   = 1'b0;
        set_magnet = 1'b0;
        unique case (r_in_word.op)
            OP_TICK:       is_tick    = 1'b1;
            OP_SET_BASE:   set_base   = 1'b1;
            OP_SET_MAGNET: set_magnet = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        base_cmd.tick     = is_tick;
        base_cmd.wrapped  = wrapped;
        base_cmd.count    = count;
        base_cmd.set      = set_base;
        base_cmd.target   = target;
        base_cmd.interval = r_in_word.step_frames;
        magnet_cmd        = base_cmd;
        magnet_cmd.set    = set_magnet;
    end

    dsps_chan u_base (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cmd   (base_cmd),
        .o_stat  (base_stat)
    );

    dsps_chan u_magnet (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cmd   (magnet_cmd),
        .o_stat  (magnet_stat)
    );

    always_comb begin
        n_tick_count = r_tick_count;
        if (is_tick) begin
            n_tick_count = wrapped ? '0 : count[CountW-1:0];
        end
        n_out_word.base_pulse    = base_stat.level;
        n_out_word.magnet_pulse  = magnet_stat.level;
        n_out_word.base_width    = base_stat.width;
        n_out_word.magnet_width  = magnet_stat.width;
        n_out_word.base_moving   = base_stat.moving;
        n_out_word.magnet_moving = magnet_stat.moving;
        n_out_word.frame_end     = is_tick && wrapped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_ticks  <= RST_FRAME_TICKS;
            r_angle_offset <= RST_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_TICKS:  r_frame_ticks  <= i_cfg_data;
                REG_ANGLE_OFFSET: r_angle_offset <= i_cfg_data[OffsetW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_out_valid  <= 1'b0;
        end else if (adv) begin
            r_tick_count <= n_tick_count;
            r_out_valid  <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid  <= 1'b0;
        end
        if (adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    a_wrap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_tick && wrapped) |=> (r_tick_count == '0))
        else $error("tick counter not cleared after frame end");

    a_free_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> o_out_valid)
        else $error("pending word did not reach the result register");

    a_set_no_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !is_tick) |=> !o_out_word.frame_end)
        else $error("frame end reported for a word that is not a tick");
`endif

endmodule

`default_nettype wire
